[sv/mzr_pkg.sv]
// Shared types and constants for the move-to-front / zero-run encoder.
// Used by every module of the block; no dependencies.
package mzr_pkg;

    localparam int BLOCK_SIZE = 32768;
    localparam int POS_W      = 15;
    localparam int LIST_N     = 256;
    localparam int FIFO_N     = 4;
    localparam int FIFO_AW    = 2;
    localparam logic [15:0] RUN_MAX   = 16'd65534;
    localparam logic [7:0]  ESC_BYTE  = 8'd255;
    localparam logic [8:0]  BIN_RUN   = 9'd256;
    localparam logic [8:0]  BIN_FIRST = 9'd260;

    // One coding command handed from the front to the back.
    typedef struct packed {
        logic [15:0]      run_v;   // run length + 1 to flush
        logic [3:0]       ndig;    // digit count below the leading one
        logic             has_sym;
        logic [7:0]       k;
        logic             bump;
        logic             last;
        logic [POS_W-1:0] prim;
    } t_cmd;

    typedef struct packed {
        logic             block_end;
        logic [POS_W-1:0] primary_index;
        logic             after_run_bump;
        logic [8:0]       hist_bin;
        logic             hist_valid;
        logic [7:0]       out_byte;
    } t_res;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_ESC,
        B_SYM
    } t_bstate;

endpackage

[sv/mzr_fifo.sv]
// Small command queue between the front and back parts.
// Depends on mzr_pkg.
module mzr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mzr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mzr_pkg::t_cmd o_data
);
    import mzr_pkg::*;

    t_cmd               r_mem [FIFO_N];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_N));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

[sv/mzr_front.sv]
// Front part: move-to-front list, run counter, block position; builds commands.
// Depends on mzr_pkg.
module mzr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [7:0]    i_symbol,
    input  logic [15:0]   i_suffix_start,
    input  logic          i_block_last,
    output logic          o_push,
    output mzr_pkg::t_cmd o_cmd
);
    import mzr_pkg::*;

    logic [7:0]       r_list [LIST_N];
    logic [15:0]      r_run;
    logic [POS_W-1:0] r_pos, r_prim;

    logic [LIST_N-1:0] match;
    logic [7:0]        k;
    logic              hit;
    logic [15:0]       run_inc, run_fl, v;
    logic [3:0]        top;
    logic [POS_W-1:0]  n_prim;
    logic [POS_W:0]    pos_inc;

    always_comb begin
        k = '0;
        for (int i = 0; i < LIST_N; i++) begin
            match[i] = (r_list[i] == i_symbol);
            if (match[i]) k = k | 8'(i);
        end
        hit = match[0];
    end

    always_comb begin
        run_inc = (r_run < RUN_MAX) ? r_run + 16'd1 : r_run;
        run_fl  = hit ? run_inc : r_run;
        v       = run_fl + 16'd1;
        top     = '0;
        for (int b = 1; b < 16; b++) begin
            if (v[b]) top = 4'(b);
        end
        if (i_suffix_start == 16'd1 ||
            (i_suffix_start == 16'd0 && i_block_last && r_pos == '0))
            n_prim = r_pos;
        else
            n_prim = r_prim;
        pos_inc = {1'b0, r_pos} + 1'b1;
    end

    assign o_push = i_acc && (!hit || i_block_last);

    always_comb begin
        o_cmd.has_sym = !hit;
        o_cmd.k       = k;
        o_cmd.bump    = !hit && (r_run != '0);
        o_cmd.last    = i_block_last;
        o_cmd.prim    = n_prim;
        // a front hit flushes only on the last item
        if (!hit || i_block_last) begin
            o_cmd.run_v = v;
            o_cmd.ndig  = top;
        end else begin
            o_cmd.run_v = '0;
            o_cmd.ndig  = '0;
        end
        if (!hit && r_run == '0) begin
            o_cmd.ndig = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIST_N; i++) r_list[i] <= 8'(i);
            r_run  <= '0;
            r_pos  <= '0;
            r_prim <= '0;
        end else if (i_acc) begin
            if (i_block_last) begin
                for (int i = 0; i < LIST_N; i++) r_list[i] <= 8'(i);
                r_run  <= '0;
                r_pos  <= '0;
                r_prim <= '0;
            end else begin
                r_list[0] <= i_symbol;
                for (int i = 1; i < LIST_N; i++) begin
                    if (8'(i) <= k) r_list[i] <= r_list[i-1];
                end
                r_run  <= hit ? run_inc : '0;
                r_prim <= n_prim;
                if (32'(pos_inc) >= BLOCK_SIZE) r_pos <= '0;
                else                            r_pos <= pos_inc[POS_W-1:0];
            end
        end
    end
endmodule

[sv/mzr_back.sv]
// Back part: expands a command into run digit, escape and symbol beats.
// Depends on mzr_pkg.
module mzr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  mzr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    output mzr_pkg::t_res o_res,
    output logic          o_last,
    input  logic          i_ready
);
    import mzr_pkg::*;

    t_bstate r_state, n_state;
    t_cmd    r_cmd;
    logic [3:0] r_idx;
    logic    r_first;
    logic    r_valid;
    t_res    r_res;
    logic    r_last;

    logic    free, emit, rlast, esc, d;
    t_res    res;

    assign free  = !r_valid || i_ready;
    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign esc   = (r_cmd.k[7:1] == 7'h7F);
    assign d     = r_cmd.run_v[r_idx];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.ndig != '0)       n_state = B_RUN;
                    else if (i_cmd.k[7:1] == 7'h7F) n_state = B_ESC;
                    else                        n_state = B_SYM;
                end
            end
            B_RUN: begin
                if (free && r_idx == '0) begin
                    if (!r_cmd.has_sym) n_state = B_IDLE;
                    else if (esc)       n_state = B_ESC;
                    else                n_state = B_SYM;
                end
            end
            B_ESC: if (free) n_state = B_SYM;
            B_SYM: if (free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        res   = '0;
        emit  = 1'b0;
        rlast = 1'b0;
        case (r_state)
            B_RUN: begin
                emit = free;
                res.hist_valid = 1'b1;
                if (r_first) begin
                    res.out_byte = {6'd0, 1'b1, d};
                    res.hist_bin = BIN_FIRST + {8'd0, d};
                end else begin
                    res.out_byte = {7'd0, d};
                    res.hist_bin = BIN_RUN + {8'd0, d};
                end
                rlast = (r_idx == '0) && !r_cmd.has_sym;
            end
            B_ESC: begin
                emit = free;
                res.out_byte       = ESC_BYTE;
                res.after_run_bump = r_cmd.bump;
            end
            B_SYM: begin
                emit = free;
                res.hist_valid     = 1'b1;
                res.hist_bin       = {1'b0, r_cmd.k - 8'd1};
                res.out_byte       = esc ? r_cmd.k : r_cmd.k + 8'd1;
                res.after_run_bump = r_cmd.bump && !esc;
                rlast = 1'b1;
            end
            default: emit = 1'b0;
        endcase
        res.block_end     = rlast && r_cmd.last;
        res.primary_index = res.block_end ? r_cmd.prim : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_idx   <= i_cmd.ndig - 4'd1;
            r_first <= 1'b1;
        end else if (r_state == B_RUN && free) begin
            r_idx   <= r_idx - 4'd1;
            r_first <= 1'b0;
        end
        if (free) begin
            r_res  <= res;
            r_last <= rlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (free) r_valid <= emit;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;
endmodule

[sv/mtf_zero_run_encoder_top.sv]
// Top level of the move-to-front / zero-run encoder.
// Depends on mzr_pkg, mzr_front, mzr_fifo, mzr_back.
//
// Input stream: one beat per BWT byte. tdata carries the symbol and its sorted
// suffix start; tlast marks the block's final byte. Output stream: one beat
// per coded byte with its histogram bin, bump flag and, on the block's final
// beat, the primary index; tlast marks the last beat caused by an input byte.
//
// The front part looks up the byte in a 256-entry move-to-front list with a
// parallel compare and updates list, run counter and position in the same
// cycle it takes the beat. A byte that needs output posts one command into a
// four-deep queue; a front hit that is not the block's last posts nothing.
// The back part takes a command while idle, then emits one output beat per
// cycle while the receiver is ready (run digits, optional escape, symbol).
// It pops no new command until the current one's last beat is emitted. A
// command yields up to 17 beats for a long flushed run plus an escape.
// When the receiver stalls, the registered output beat holds; the queue keeps
// taking beats until it fills, then the input tready drops.
// Reset (synchronous, active low) restores the identity list, clears run,
// position and primary index, and empties the queue and output register.
module mtf_zero_run_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // symbol[7:0], suffix_start[23:8]
    input  logic        i_s_tlast,   // block_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_byte[7:0], hist_valid[8], hist_bin[17:9], after_run_bump[18],
    // primary_index[33:19], block_end[34], zero fill [39:35]
    output logic [39:0] o_m_tdata,
    output logic        o_m_tlast    // result_last
);
    import mzr_pkg::*;

    logic  acc, push, full, pop, empty;
    t_cmd  cmd_in, cmd_out;
    t_res  res;

    assign o_s_tready = !full;
    assign acc        = i_s_tvalid && !full;

    mzr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_symbol       (i_s_tdata[7:0]),
        .i_suffix_start (i_s_tdata[23:8]),
        .i_block_last   (i_s_tlast),
        .o_push         (push),
        .o_cmd          (cmd_in)
    );

    mzr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (cmd_out)
    );

    mzr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_res   (res),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {5'd0, res};
endmodule
